@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define POFTR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// when ante holds, cons holds in the cycle after
`define POFTR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/poftr_pkg.sv @@
// ---------------------------------------------------------------------------
// poftr_pkg
// widths, queue entry types and saturating helpers of the force/torque reducer
// ---------------------------------------------------------------------------
package poftr_pkg;

  localparam int IDX_W          = 10;
  localparam int IN_W           = 32;
  localparam int ARM_W          = IN_W + 1;
  localparam int PROD_W         = ARM_W + IN_W;
  localparam int FRAC_W         = 16;
  localparam int CROSS_W        = PROD_W - FRAC_W;
  localparam int ACC_W          = 48;
  localparam int EXT_W          = ACC_W + 2;
  localparam int NUM_COMP       = 6;
  localparam int QUEUE_DEPTH    = 4;
  localparam int BODY_COUNT_DEF = 1024;

  // component slots of the sum vectors
  localparam int C_FX = 0;
  localparam int C_FY = 1;
  localparam int C_FZ = 2;
  localparam int C_TX = 3;
  localparam int C_TY = 4;
  localparam int C_TZ = 5;

  localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic [NUM_COMP-1:0][ACC_W-1:0] vec6_t;

  typedef struct packed {
    logic [IN_W-1:0]    fx;
    logic [IN_W-1:0]    fy;
    logic [IN_W-1:0]    fz;
    logic [CROSS_W-1:0] tx;
    logic [CROSS_W-1:0] ty;
    logic [CROSS_W-1:0] tz;
    logic [IDX_W-1:0]   idx;
    logic               last;
    logic               empty;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } qwr_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qrd_t;

  // clamp a two-guard-bit value to the 48-bit range
  function automatic logic [ACC_W-1:0] sat48(input logic [EXT_W-1:0] v);
    logic [ACC_W-1:0] r;
    if (v[EXT_W-1:ACC_W-1] == '0 || v[EXT_W-1:ACC_W-1] == '1) begin
      r = v[ACC_W-1:0];
    end else if (v[EXT_W-1]) begin
      r = SAT_MIN;
    end else begin
      r = SAT_MAX;
    end
    return r;
  endfunction

  // difference of two products, each floored to q16.16
  function automatic logic [CROSS_W-1:0] cross_q16(input logic [PROD_W-1:0] pa,
                                                   input logic [PROD_W-1:0] pb);
    logic [CROSS_W:0] d;
    d = {pa[PROD_W-1], pa[PROD_W-1:FRAC_W]} - {pb[PROD_W-1], pb[PROD_W-1:FRAC_W]};
    return d[CROSS_W-1:0];
  endfunction

endpackage

@@ hdl/poftr_ram.sv @@
// ---------------------------------------------------------------------------
// poftr_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module poftr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/poftr_front.sv @@
// ---------------------------------------------------------------------------
// poftr_front
// takes samples, forms lever arms and cross products, pushes to the queue
// ---------------------------------------------------------------------------
module poftr_front import poftr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   hold,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] in_force_x,
  input  logic signed [IN_W-1:0] in_force_y,
  input  logic signed [IN_W-1:0] in_force_z,
  input  logic signed [IN_W-1:0] in_point_x,
  input  logic signed [IN_W-1:0] in_point_y,
  input  logic signed [IN_W-1:0] in_point_z,
  input  logic signed [IN_W-1:0] in_body_x,
  input  logic signed [IN_W-1:0] in_body_y,
  input  logic signed [IN_W-1:0] in_body_z,
  input  logic [IDX_W-1:0]       in_body_index,
  input  logic                   in_last_of_body,
  input  logic                   in_empty_body,
  input  logic                   q_full,
  output qwr_t                   q_wr
);

  logic                     adv;
  logic                     take;

  // stage a: arm and force
  logic                     sa_v_r;
  logic signed [IN_W-1:0]   sa_fx_r, sa_fy_r, sa_fz_r;
  logic signed [ARM_W-1:0]  sa_dx_r, sa_dy_r, sa_dz_r;
  logic [IDX_W-1:0]         sa_idx_r;
  logic                     sa_last_r, sa_empty_r;

  // stage b: products
  logic                     sb_v_r;
  logic [IN_W-1:0]          sb_fx_r, sb_fy_r, sb_fz_r;
  logic signed [PROD_W-1:0] p_dyfz_r, p_dzfy_r, p_dzfx_r, p_dxfz_r, p_dxfy_r, p_dyfx_r;
  logic [IDX_W-1:0]         sb_idx_r;
  logic                     sb_last_r, sb_empty_r;

  // whole pipe moves unless the tail is blocked by a full queue
  assign adv      = !sb_v_r || !q_full;
  assign in_stall = !adv || hold;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
      sb_v_r <= 1'b0;
    end else if (adv) begin
      sa_v_r <= take;
      sb_v_r <= sa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_fx_r    <= in_force_x;
      sa_fy_r    <= in_force_y;
      sa_fz_r    <= in_force_z;
      sa_dx_r    <= {in_point_x[IN_W-1], in_point_x} - {in_body_x[IN_W-1], in_body_x};
      sa_dy_r    <= {in_point_y[IN_W-1], in_point_y} - {in_body_y[IN_W-1], in_body_y};
      sa_dz_r    <= {in_point_z[IN_W-1], in_point_z} - {in_body_z[IN_W-1], in_body_z};
      sa_idx_r   <= in_body_index;
      sa_last_r  <= in_last_of_body;
      sa_empty_r <= in_empty_body;

      sb_fx_r    <= sa_fx_r;
      sb_fy_r    <= sa_fy_r;
      sb_fz_r    <= sa_fz_r;
      p_dyfz_r   <= sa_dy_r * sa_fz_r;
      p_dzfy_r   <= sa_dz_r * sa_fy_r;
      p_dzfx_r   <= sa_dz_r * sa_fx_r;
      p_dxfz_r   <= sa_dx_r * sa_fz_r;
      p_dxfy_r   <= sa_dx_r * sa_fy_r;
      p_dyfx_r   <= sa_dy_r * sa_fx_r;
      sb_idx_r   <= sa_idx_r;
      sb_last_r  <= sa_last_r;
      sb_empty_r <= sa_empty_r;
    end
  end

  always_comb begin
    q_wr.push      = sb_v_r && !q_full;
    q_wr.ent.fx    = sb_fx_r;
    q_wr.ent.fy    = sb_fy_r;
    q_wr.ent.fz    = sb_fz_r;
    q_wr.ent.tx    = cross_q16(p_dyfz_r, p_dzfy_r);
    q_wr.ent.ty    = cross_q16(p_dzfx_r, p_dxfz_r);
    q_wr.ent.tz    = cross_q16(p_dxfy_r, p_dyfx_r);
    q_wr.ent.idx   = sb_idx_r;
    q_wr.ent.last  = sb_last_r;
    q_wr.ent.empty = sb_empty_r;
  end

endmodule

@@ hdl/poftr_queue.sv @@
// ---------------------------------------------------------------------------
// poftr_queue
// short register fifo between the front and the back
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module poftr_queue import poftr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  qwr_t q_wr,
  output logic q_full,
  output qrd_t q_rd,
  input  logic q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t            ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.ent   = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr.push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_wr.push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      ent_r[wr_ptr_r] <= q_wr.ent;
    end
  end

  `POFTR_ASSERT(a_q_no_overflow, q_wr.push |-> !q_full, "push into a full queue")
  `POFTR_ASSERT(a_q_no_underflow, q_pop |-> (cnt_r != '0), "pop from an empty queue")
  `POFTR_ASSERT(a_q_cnt_bound, cnt_r <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

@@ hdl/poftr_back.sv @@
// ---------------------------------------------------------------------------
// poftr_back
// running sums, per-body previous totals, increments and output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module poftr_back import poftr_pkg::*; #(
  parameter int BODY_COUNT = BODY_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qrd_t                    q_rd,
  output logic                    q_pop,
  output logic                    clr_busy,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACC_W-1:0] out_total_fx,
  output logic signed [ACC_W-1:0] out_total_fy,
  output logic signed [ACC_W-1:0] out_total_fz,
  output logic signed [ACC_W-1:0] out_total_tx,
  output logic signed [ACC_W-1:0] out_total_ty,
  output logic signed [ACC_W-1:0] out_total_tz,
  output logic signed [ACC_W-1:0] out_delta_fx,
  output logic signed [ACC_W-1:0] out_delta_fy,
  output logic signed [ACC_W-1:0] out_delta_fz,
  output logic signed [ACC_W-1:0] out_delta_tx,
  output logic signed [ACC_W-1:0] out_delta_ty,
  output logic signed [ACC_W-1:0] out_delta_tz
);

  localparam int PREV_DEPTH = (BODY_COUNT < (1 << IDX_W)) ? BODY_COUNT : (1 << IDX_W);
  localparam int ADDR_W     = (PREV_DEPTH > 1) ? $clog2(PREV_DEPTH) : 1;
  localparam int MEM_W      = NUM_COMP * ACC_W;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } clr_state_t;

  clr_state_t        st_r, st_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;

  vec6_t             acc_r;
  logic [EXT_W-1:0]  term [NUM_COMP];
  vec6_t             sum_sat;
  logic              close;
  logic              in_range;
  logic [ADDR_W-1:0] head_addr;

  logic              s2_v_r;
  vec6_t             s2_tot_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic              s2_inr_r;
  logic              s2_fire;
  logic              s2_ready;

  logic              fwd_hit_r;
  vec6_t             fwd_tot_r;
  vec6_t             prv;
  vec6_t             dlt;

  logic              out_v_r;
  vec6_t             out_tot_r;
  vec6_t             out_dlt_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [MEM_W-1:0]  mem_rdata;
  logic              run_we;

  // clearing pass over the previous-total store
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(PREV_DEPTH - 1)) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        st_nxt = ST_RUN;
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  assign clr_busy = (st_r != ST_RUN);

  // stage 1: running sums on the queue head
  assign close     = q_rd.ent.last || q_rd.ent.empty;
  assign in_range  = (32'(q_rd.ent.idx) < BODY_COUNT);
  assign head_addr = q_rd.ent.idx[ADDR_W-1:0];

  always_comb begin
    term[C_FX] = {{(EXT_W-IN_W){q_rd.ent.fx[IN_W-1]}}, q_rd.ent.fx};
    term[C_FY] = {{(EXT_W-IN_W){q_rd.ent.fy[IN_W-1]}}, q_rd.ent.fy};
    term[C_FZ] = {{(EXT_W-IN_W){q_rd.ent.fz[IN_W-1]}}, q_rd.ent.fz};
    term[C_TX] = {{(EXT_W-CROSS_W){q_rd.ent.tx[CROSS_W-1]}}, q_rd.ent.tx};
    term[C_TY] = {{(EXT_W-CROSS_W){q_rd.ent.ty[CROSS_W-1]}}, q_rd.ent.ty};
    term[C_TZ] = {{(EXT_W-CROSS_W){q_rd.ent.tz[CROSS_W-1]}}, q_rd.ent.tz};
    for (int k = 0; k < NUM_COMP; k++) begin
      if (q_rd.ent.empty) begin
        sum_sat[k] = acc_r[k];
      end else begin
        sum_sat[k] = sat48({{(EXT_W-ACC_W){acc_r[k][ACC_W-1]}}, acc_r[k]} + term[k]);
      end
    end
  end

  assign s2_fire  = s2_v_r && (!out_v_r || !out_stall);
  assign s2_ready = !s2_v_r || s2_fire;
  assign q_pop    = (st_r == ST_RUN) && q_rd.valid && (!close || s2_ready);
  assign mem_re   = q_pop && close && in_range;
  assign run_we   = s2_fire && s2_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      s2_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        acc_r <= close ? '0 : sum_sat;
      end
      if (q_pop && close) begin
        s2_v_r <= 1'b1;
      end else if (s2_fire) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && close) begin
      s2_tot_r  <= sum_sat;
      s2_addr_r <= head_addr;
      s2_inr_r  <= in_range;
    end
    // a write to the same entry in the read cycle is not seen by the ram read
    if (mem_re) begin
      fwd_hit_r <= run_we && (s2_addr_r == head_addr);
      fwd_tot_r <= s2_tot_r;
    end
  end

  // stage 2: increments against the previous totals
  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      if (!s2_inr_r) begin
        prv[k] = '0;
      end else if (fwd_hit_r) begin
        prv[k] = fwd_tot_r[k];
      end else begin
        prv[k] = mem_rdata[k*ACC_W +: ACC_W];
      end
      dlt[k] = sat48({{(EXT_W-ACC_W){s2_tot_r[k][ACC_W-1]}}, s2_tot_r[k]}
                   - {{(EXT_W-ACC_W){prv[k][ACC_W-1]}}, prv[k]});
    end
  end

  assign mem_we    = clr_busy || run_we;
  assign mem_waddr = clr_busy ? clr_cnt_r : s2_addr_r;
  assign mem_wdata = clr_busy ? '0 : MEM_W'(s2_tot_r);

  poftr_ram #(
    .WIDTH (MEM_W),
    .DEPTH (PREV_DEPTH)
  ) u_prev_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (head_addr),
    .rd_data (mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_fire) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_tot_r <= s2_tot_r;
      out_dlt_r <= dlt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_total_fx = out_tot_r[C_FX];
  assign out_total_fy = out_tot_r[C_FY];
  assign out_total_fz = out_tot_r[C_FZ];
  assign out_total_tx = out_tot_r[C_TX];
  assign out_total_ty = out_tot_r[C_TY];
  assign out_total_tz = out_tot_r[C_TZ];
  assign out_delta_fx = out_dlt_r[C_FX];
  assign out_delta_fy = out_dlt_r[C_FY];
  assign out_delta_fz = out_dlt_r[C_FZ];
  assign out_delta_tx = out_dlt_r[C_TX];
  assign out_delta_ty = out_dlt_r[C_TY];
  assign out_delta_tz = out_dlt_r[C_TZ];

  `POFTR_ASSERT(a_bk_idle_in_clear, (st_r == ST_CLEAR) |-> !q_rd.valid, "queue busy during clear")
  `POFTR_ASSERT_NEXT(a_bk_close_loads, q_pop && close, s2_v_r, "closing item lost")
  `POFTR_ASSERT(a_bk_out_from_s2, $rose(out_v_r) |-> $past(s2_fire), "result without stage 2")

endmodule

@@ hdl/per_owner_force_torque_reducer.sv @@
// ---------------------------------------------------------------------------
// per_owner_force_torque_reducer
// sums sample forces and torques per owning body and reports totals and
// increments against that body's totals of the previous pass
// ---------------------------------------------------------------------------
// path: input stages a and b, queue, stage 1, stage 2, output register, out_valid
// throughput: one sample transaction per cycle while in_stall is low,
//   results one per cycle while out_stall is low
// reset: after rst_n the previous-total store is zeroed one entry a cycle,
//   all min(BODY_COUNT, 1024) entries, with in_stall high
module per_owner_force_torque_reducer import poftr_pkg::*; #(
  parameter int BODY_COUNT = BODY_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // sample channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  in_force_x,
  input  logic signed [IN_W-1:0]  in_force_y,
  input  logic signed [IN_W-1:0]  in_force_z,
  input  logic signed [IN_W-1:0]  in_point_x,
  input  logic signed [IN_W-1:0]  in_point_y,
  input  logic signed [IN_W-1:0]  in_point_z,
  input  logic signed [IN_W-1:0]  in_body_x,
  input  logic signed [IN_W-1:0]  in_body_y,
  input  logic signed [IN_W-1:0]  in_body_z,
  input  logic [IDX_W-1:0]        in_body_index,
  input  logic                    in_last_of_body,
  input  logic                    in_empty_body,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACC_W-1:0] out_total_fx,
  output logic signed [ACC_W-1:0] out_total_fy,
  output logic signed [ACC_W-1:0] out_total_fz,
  output logic signed [ACC_W-1:0] out_total_tx,
  output logic signed [ACC_W-1:0] out_total_ty,
  output logic signed [ACC_W-1:0] out_total_tz,
  output logic signed [ACC_W-1:0] out_delta_fx,
  output logic signed [ACC_W-1:0] out_delta_fy,
  output logic signed [ACC_W-1:0] out_delta_fz,
  output logic signed [ACC_W-1:0] out_delta_tx,
  output logic signed [ACC_W-1:0] out_delta_ty,
  output logic signed [ACC_W-1:0] out_delta_tz
);

  // front to queue and queue to back
  qwr_t q_wr;
  qrd_t q_rd;
  logic q_full;
  logic q_pop;
  // back end still zeroing its store
  logic clr_busy;

  // front: input register with lever arms, then the six products behind the three cross terms;
  // the cross terms are floored to q16.16 on the way into the queue
  poftr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .hold            (clr_busy),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_force_x      (in_force_x),
    .in_force_y      (in_force_y),
    .in_force_z      (in_force_z),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_body_x       (in_body_x),
    .in_body_y       (in_body_y),
    .in_body_z       (in_body_z),
    .in_body_index   (in_body_index),
    .in_last_of_body (in_last_of_body),
    .in_empty_body   (in_empty_body),
    .q_full          (q_full),
    .q_wr            (q_wr)
  );

  // decoupling queue, lets the front keep taking samples while results wait
  poftr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // back: running sums, previous-total lookup with write forwarding,
  // saturated increments, output register
  poftr_back #(
    .BODY_COUNT (BODY_COUNT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_rd         (q_rd),
    .q_pop        (q_pop),
    .clr_busy     (clr_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_total_fx (out_total_fx),
    .out_total_fy (out_total_fy),
    .out_total_fz (out_total_fz),
    .out_total_tx (out_total_tx),
    .out_total_ty (out_total_ty),
    .out_total_tz (out_total_tz),
    .out_delta_fx (out_delta_fx),
    .out_delta_fy (out_delta_fy),
    .out_delta_fz (out_delta_fz),
    .out_delta_tx (out_delta_tx),
    .out_delta_ty (out_delta_ty),
    .out_delta_tz (out_delta_tz)
  );

endmodule

@@ bench/poftr_result_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// poftr_result_checker
// watches both channels of the force/torque reducer, folds every accepted
// sample into its own running sums and per-body store, and compares each
// result transaction field by field with the oldest report still due
// ---------------------------------------------------------------------------
module poftr_result_checker import poftr_pkg::*; #(
  parameter int BODY_COUNT = BODY_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [IN_W-1:0]  in_force_x,
  input  logic signed [IN_W-1:0]  in_force_y,
  input  logic signed [IN_W-1:0]  in_force_z,
  input  logic signed [IN_W-1:0]  in_point_x,
  input  logic signed [IN_W-1:0]  in_point_y,
  input  logic signed [IN_W-1:0]  in_point_z,
  input  logic signed [IN_W-1:0]  in_body_x,
  input  logic signed [IN_W-1:0]  in_body_y,
  input  logic signed [IN_W-1:0]  in_body_z,
  input  logic [IDX_W-1:0]        in_body_index,
  input  logic                    in_last_of_body,
  input  logic                    in_empty_body,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [ACC_W-1:0] out_total_fx,
  input  logic signed [ACC_W-1:0] out_total_fy,
  input  logic signed [ACC_W-1:0] out_total_fz,
  input  logic signed [ACC_W-1:0] out_total_tx,
  input  logic signed [ACC_W-1:0] out_total_ty,
  input  logic signed [ACC_W-1:0] out_total_tz,
  input  logic signed [ACC_W-1:0] out_delta_fx,
  input  logic signed [ACC_W-1:0] out_delta_fy,
  input  logic signed [ACC_W-1:0] out_delta_fz,
  input  logic signed [ACC_W-1:0] out_delta_tx,
  input  logic signed [ACC_W-1:0] out_delta_ty,
  input  logic signed [ACC_W-1:0] out_delta_tz,
  output int                      results_due,
  output int                      mismatch_count
);

  typedef struct packed {
    vec6_t total;
    vec6_t delta;
  } body_report_t;

  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -64'sh0000_8000_0000_0000;

  longint       run_sum   [NUM_COMP];
  longint       last_pass [BODY_COUNT][NUM_COMP];
  body_report_t reports_due [$];
  string        comp_name [NUM_COMP] = '{"fx", "fy", "fz", "tx", "ty", "tz"};

  function automatic longint clamp48(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // a*b - c*d with each product floored to q16.16
  function automatic longint cross_part(input longint a, input longint b,
                                        input longint c, input longint d);
    return ((a * b) >>> FRAC_W) - ((c * d) >>> FRAC_W);
  endfunction

  task automatic fold_sample();
    longint       fx, fy, fz, px, py, pz, bx, by, bz, dx, dy, dz;
    longint       prior;
    body_report_t rep;
    if (!in_empty_body) begin
      fx = in_force_x;
      fy = in_force_y;
      fz = in_force_z;
      px = in_point_x;
      py = in_point_y;
      pz = in_point_z;
      bx = in_body_x;
      by = in_body_y;
      bz = in_body_z;
      dx = px - bx;
      dy = py - by;
      dz = pz - bz;
      run_sum[C_FX] = clamp48(run_sum[C_FX] + fx);
      run_sum[C_FY] = clamp48(run_sum[C_FY] + fy);
      run_sum[C_FZ] = clamp48(run_sum[C_FZ] + fz);
      run_sum[C_TX] = clamp48(run_sum[C_TX] + cross_part(dy, fz, dz, fy));
      run_sum[C_TY] = clamp48(run_sum[C_TY] + cross_part(dz, fx, dx, fz));
      run_sum[C_TZ] = clamp48(run_sum[C_TZ] + cross_part(dx, fy, dy, fx));
    end
    // an empty body closes whatever its last flag says
    if (in_last_of_body || in_empty_body) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        prior = 0;
        if (int'(in_body_index) < BODY_COUNT) begin
          prior = last_pass[in_body_index][k];
          last_pass[in_body_index][k] = run_sum[k];
        end
        rep.total[k] = ACC_W'(run_sum[k]);
        rep.delta[k] = ACC_W'(clamp48(run_sum[k] - prior));
        run_sum[k] = 0;
      end
      reports_due.push_back(rep);
    end
  endtask

  task automatic check_report();
    body_report_t want;
    vec6_t        got_total;
    vec6_t        got_delta;
    got_total[C_FX] = out_total_fx;
    got_total[C_FY] = out_total_fy;
    got_total[C_FZ] = out_total_fz;
    got_total[C_TX] = out_total_tx;
    got_total[C_TY] = out_total_ty;
    got_total[C_TZ] = out_total_tz;
    got_delta[C_FX] = out_delta_fx;
    got_delta[C_FY] = out_delta_fy;
    got_delta[C_FZ] = out_delta_fz;
    got_delta[C_TX] = out_delta_tx;
    got_delta[C_TY] = out_delta_ty;
    got_delta[C_TZ] = out_delta_tz;
    if (reports_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual total_fx %0d",
               $time, $signed(out_total_fx));
      mismatch_count++;
    end else begin
      want = reports_due.pop_front();
      for (int k = 0; k < NUM_COMP; k++) begin
        if (got_total[k] !== want.total[k]) begin
          $display("%0t: total_%s expected %0d actual %0d", $time, comp_name[k],
                   $signed(want.total[k]), $signed(got_total[k]));
          mismatch_count++;
        end
        if (got_delta[k] !== want.delta[k]) begin
          $display("%0t: delta_%s expected %0d actual %0d", $time, comp_name[k],
                   $signed(want.delta[k]), $signed(got_delta[k]));
          mismatch_count++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        run_sum[k] = 0;
        for (int b = 0; b < BODY_COUNT; b++) begin
          last_pass[b][k] = 0;
        end
      end
      reports_due.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_report();
      end
      if (in_valid && !in_stall) begin
        fold_sample();
      end
    end
    results_due = reports_due.size();
  end

endmodule

@@ bench/per_owner_force_torque_reducer_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// per_owner_force_torque_reducer_tb
// drives surface samples grouped by body into the force/torque reducer, with
// directed extremes, a back-pressure phase and a random phase of body
// sequences; a checker beside the block predicts every result and counts
// mismatches
// ---------------------------------------------------------------------------
module per_owner_force_torque_reducer_tb;
  import poftr_pkg::*;

  // stimulus sizes
  localparam int RANDOM_ITEMS  = 550;
  localparam int CALM_ITEMS    = 100;   // tail of the random phase, no idling
  localparam int LONG_HOLD     = 150;   // receiver hold-off in cycles
  localparam int PRESSURE_BODY = 30;

  // handy q16.16 words
  localparam logic [IN_W-1:0] W_MAX   = 32'h7FFF_FFFF;
  localparam logic [IN_W-1:0] W_MIN   = 32'h8000_0000;
  localparam logic [IN_W-1:0] ONE     = 32'h0001_0000;
  localparam logic [IN_W-1:0] NEG_LSB = 32'hFFFF_FFFF;

  // one sample transaction, element 0 is x
  typedef struct packed {
    logic [2:0][IN_W-1:0] frc;
    logic [2:0][IN_W-1:0] pnt;
    logic [2:0][IN_W-1:0] ctr;
    logic [IDX_W-1:0]     idx;
    logic                 last;
    logic                 empty;
  } sample_t;

  logic                    clk;
  logic                    rst_n           = 1'b0;
  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic signed [IN_W-1:0]  in_force_x      = '0;
  logic signed [IN_W-1:0]  in_force_y      = '0;
  logic signed [IN_W-1:0]  in_force_z      = '0;
  logic signed [IN_W-1:0]  in_point_x      = '0;
  logic signed [IN_W-1:0]  in_point_y      = '0;
  logic signed [IN_W-1:0]  in_point_z      = '0;
  logic signed [IN_W-1:0]  in_body_x       = '0;
  logic signed [IN_W-1:0]  in_body_y       = '0;
  logic signed [IN_W-1:0]  in_body_z       = '0;
  logic [IDX_W-1:0]        in_body_index   = '0;
  logic                    in_last_of_body = 1'b0;
  logic                    in_empty_body   = 1'b0;
  logic                    out_valid;
  logic                    out_stall       = 1'b0;
  logic signed [ACC_W-1:0] out_total_fx, out_total_fy, out_total_fz;
  logic signed [ACC_W-1:0] out_total_tx, out_total_ty, out_total_tz;
  logic signed [ACC_W-1:0] out_delta_fx, out_delta_fy, out_delta_fz;
  logic signed [ACC_W-1:0] out_delta_tx, out_delta_ty, out_delta_tz;

  int results_due;
  int mismatch_count;

  // calm switches off random idling on both sides, hold_req asks the
  // receiver for one long hold-off
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  per_owner_force_torque_reducer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_force_x      (in_force_x),
    .in_force_y      (in_force_y),
    .in_force_z      (in_force_z),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_body_x       (in_body_x),
    .in_body_y       (in_body_y),
    .in_body_z       (in_body_z),
    .in_body_index   (in_body_index),
    .in_last_of_body (in_last_of_body),
    .in_empty_body   (in_empty_body),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_total_fx    (out_total_fx),
    .out_total_fy    (out_total_fy),
    .out_total_fz    (out_total_fz),
    .out_total_tx    (out_total_tx),
    .out_total_ty    (out_total_ty),
    .out_total_tz    (out_total_tz),
    .out_delta_fx    (out_delta_fx),
    .out_delta_fy    (out_delta_fy),
    .out_delta_fz    (out_delta_fz),
    .out_delta_tx    (out_delta_tx),
    .out_delta_ty    (out_delta_ty),
    .out_delta_tz    (out_delta_tz)
  );

  // prediction and comparison live in the checker, it only reports back
  poftr_result_checker watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_force_x      (in_force_x),
    .in_force_y      (in_force_y),
    .in_force_z      (in_force_z),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_body_x       (in_body_x),
    .in_body_y       (in_body_y),
    .in_body_z       (in_body_z),
    .in_body_index   (in_body_index),
    .in_last_of_body (in_last_of_body),
    .in_empty_body   (in_empty_body),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_total_fx    (out_total_fx),
    .out_total_fy    (out_total_fy),
    .out_total_fz    (out_total_fz),
    .out_total_tx    (out_total_tx),
    .out_total_ty    (out_total_ty),
    .out_total_tz    (out_total_tz),
    .out_delta_fx    (out_delta_fx),
    .out_delta_fy    (out_delta_fy),
    .out_delta_fz    (out_delta_fz),
    .out_delta_tx    (out_delta_tx),
    .out_delta_ty    (out_delta_ty),
    .out_delta_tz    (out_delta_tz),
    .results_due     (results_due),
    .mismatch_count  (mismatch_count)
  );

  // build a sample from explicit words
  function automatic sample_t mk(input logic [IN_W-1:0] fx, input logic [IN_W-1:0] fy,
                                 input logic [IN_W-1:0] fz, input logic [IN_W-1:0] px,
                                 input logic [IN_W-1:0] py, input logic [IN_W-1:0] pz,
                                 input logic [IN_W-1:0] bx, input logic [IN_W-1:0] by,
                                 input logic [IN_W-1:0] bz, input logic [IDX_W-1:0] idx,
                                 input logic last, input logic empty);
    sample_t s;
    s.frc   = {fz, fy, fx};
    s.pnt   = {pz, py, px};
    s.ctr   = {bz, by, bx};
    s.idx   = idx;
    s.last  = last;
    s.empty = empty;
    return s;
  endfunction

  // random word, biased toward the corners of the q16.16 range
  function automatic logic [IN_W-1:0] pick_word();
    logic [IN_W-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = W_MAX;
      1:       w = W_MIN;
      2:       w = '0;
      3:       w = $urandom_range(0, 255) << FRAC_W;
      4:       w = -($urandom_range(0, 255) << FRAC_W);
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // mostly a small pool so bodies come back and deltas are non-trivial
  function automatic logic [IDX_W-1:0] pick_index();
    logic [IDX_W-1:0] i;
    if ($urandom_range(0, 3) != 0) begin
      i = IDX_W'($urandom_range(0, 15));
    end else begin
      i = IDX_W'($urandom_range(0, 1023));
    end
    return i;
  endfunction

  function automatic sample_t rand_sample(input logic [IDX_W-1:0] idx, input logic last,
                                          input logic empty);
    return mk(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
              pick_word(), pick_word(), pick_word(), pick_word(), idx, last, empty);
  endfunction

  // present one sample transaction, maybe after an idle burst, and hold it
  // until the block takes it
  task automatic offer(input sample_t s);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_force_x      <= s.frc[0];
    in_force_y      <= s.frc[1];
    in_force_z      <= s.frc[2];
    in_point_x      <= s.pnt[0];
    in_point_y      <= s.pnt[1];
    in_point_z      <= s.pnt[2];
    in_body_x       <= s.ctr[0];
    in_body_y       <= s.ctr[1];
    in_body_z       <= s.ctr[2];
    in_body_index   <= s.idx;
    in_last_of_body <= s.last;
    in_empty_body   <= s.empty;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender goes quiet until every predicted result has come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_due == 0);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog, far beyond the slowest correct run including the store clear
  initial begin
    #10_000_000;
    $display("per_owner_force_torque_reducer verification failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int      n;
    int      len;
    int      kind;
    logic [IDX_W-1:0] idx;
    sample_t s;

    // reset held low at the start, then the block clears its store on its own
    // with in_stall high, offer() simply waits that out
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // empty body on a fresh index: all zeros, last flag low but still closes
    offer(mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), 10'd0, 1'b0, 1'b1));
    // empty body on the top index with last flag set
    offer(mk('0, '0, '0, '0, '0, '0, '0, '0, '0, 10'd1023, 1'b1, 1'b1));
    // plain unit sample, then the same body again for a real increment
    offer(mk(ONE, 2 * ONE, 3 * ONE, ONE, '0, '0, '0, '0, '0, 10'd5, 1'b1, 1'b0));
    offer(mk(-ONE, ONE, -(4 * ONE), '0, ONE, -ONE, ONE, '0, '0, 10'd5, 1'b1, 1'b0));
    // full-scale arms and forces: torque clamps at the top, then a second
    // sample pulls it back down from the clamped value
    offer(mk(W_MAX, W_MAX, W_MAX, '0, W_MAX, W_MIN, '0, W_MIN, W_MAX, 10'd6, 1'b0, 1'b0));
    offer(mk(W_MIN, W_MIN, W_MIN, '0, W_MAX, W_MIN, '0, W_MIN, W_MAX, 10'd6, 1'b1, 1'b0));
    // clamped positive total, then clamped negative one: increment saturates
    offer(mk(W_MAX, W_MAX, W_MAX, '0, W_MAX, W_MIN, '0, W_MIN, W_MAX, 10'd7, 1'b1, 1'b0));
    offer(mk(W_MIN, W_MIN, W_MIN, '0, W_MAX, W_MIN, '0, W_MIN, W_MAX, 10'd7, 1'b1, 1'b0));
    // open samples closed by an empty item on another index
    offer(rand_sample(10'd8, 1'b0, 1'b0));
    offer(rand_sample(10'd8, 1'b0, 1'b0));
    offer(rand_sample(10'd9, 1'b0, 1'b1));
    // forces and points at the negative corner, body centre at the positive
    offer(mk(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX,
             10'd10, 1'b1, 1'b0));
    // zero arm, full force: torque stays zero
    s = rand_sample(10'd11, 1'b1, 1'b0);
    s.frc = {W_MAX, W_MAX, W_MAX};
    s.ctr = s.pnt;
    offer(s);
    // tiny negative products, flooring toward minus infinity
    offer(mk(NEG_LSB, NEG_LSB, NEG_LSB, 32'd1, 32'd2, 32'd3, '0, '0, '0,
             10'd12, 1'b1, 1'b0));
    // five-sample body, then an empty pass on the same body
    for (int j = 0; j < 5; j++) begin
      offer(rand_sample(10'd13, j == 4, 1'b0));
    end
    offer(rand_sample(10'd13, 1'b1, 1'b1));
    offer(rand_sample(10'd1023, 1'b1, 1'b0));
    offer(rand_sample(10'd1023, 1'b1, 1'b0));
    settle();

    // ---- back-pressure: receiver holds off while one-sample bodies pour in,
    // the sample queue fills and the block stalls its input ----
    hold_req = 1'b1;
    for (int j = 0; j < PRESSURE_BODY; j++) begin
      offer(rand_sample(pick_index(), 1'b1, 1'b0));
    end
    settle();

    // ---- random body sequences, well-formed for the most part ----
    n = 0;
    while (n < RANDOM_ITEMS) begin
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      kind = $urandom_range(0, 9);
      idx  = pick_index();
      if (kind == 0) begin
        // lone empty item, last flag random
        offer(rand_sample(idx, 1'($urandom_range(0, 1)), 1'b1));
        n++;
      end else if (kind == 1) begin
        // broken sequence: wandering index, closed by an empty item
        len = $urandom_range(1, 4);
        repeat (len) begin
          offer(rand_sample(pick_index(), 1'b0, 1'b0));
          n++;
        end
        offer(rand_sample(idx, 1'($urandom_range(0, 1)), 1'b1));
        n++;
      end else begin
        // well-formed body of one to six samples
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          offer(rand_sample(idx, j == len - 1, 1'b0));
          n++;
        end
      end
    end

    // drain, then let the clock run on so a stray result is still seen
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_due == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("per_owner_force_torque_reducer verification clean");
    end else begin
      $display("per_owner_force_torque_reducer verification failed");
    end
    $finish;
  end

endmodule
